// ===== sv/rmze_pkg.sv =====
package rmze_pkg;

  localparam int ElemW = 18;
  localparam int SqW   = 34;
  localparam int RootW = 17;
  localparam int XyW   = 33;
  localparam int ZW    = 35;
  localparam int AngW  = 19;
  localparam int PreShift = 12;

  localparam logic signed [ElemW-1:0] OneQ16 = 18'sd65536;
  localparam logic signed [ZW-1:0]    PiQ30  = 35'sd3373259426;
  localparam logic signed [AngW-1:0]  PiQ16  = 19'sd205887;

  localparam logic signed [ZW-1:0] AtanTable [10] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159, 35'sd67021687,
    35'sd33543516, 35'sd16775851, 35'sd8388437, 35'sd4194283, 35'sd2097149
  };

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m11;
  } elems_t;

  function automatic logic signed [ElemW-1:0] clamp_elem(input logic signed [ElemW-1:0] v);
    logic signed [ElemW-1:0] r;
    r = v;
    if (v > OneQ16) r = OneQ16;
    if (v < -OneQ16) r = -OneQ16;
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] stage_angle(input int i);
    logic signed [ZW-1:0] a;
    a = '0;
    if (i < 10) a = AtanTable[i];
    else if (i <= 30) a = ZW'(1) <<< (30 - i);
    return a;
  endfunction

endpackage

// ===== sv/rotation_matrix_to_euler_zyx.sv =====
// ZYX Euler angles from seven elements of a rotation matrix in Q16 fixed point.
// A transaction is taken on every clock edge where start is high; busy is always
// low, so a new matrix may enter in every cycle. Elements are clamped to +-1.0.
// The pipeline squares m00 and m10, takes an exact integer square root one bit
// per stage (17 stages), then runs three CORDIC vectoring pipelines in parallel
// for yaw, pitch and roll. Throughput is one matrix per cycle.
// Each result is shown for one cycle with done high; the receiver cannot stall,
// so results must be taken as they come.
// The gimbal-lock threshold is written through the cfg channel, which is always
// ready; write it only while no transaction is in flight. Reset clears every
// valid bit in the pipeline and sets the threshold to 1, so only sy of zero
// counts as gimbal lock.
module rotation_matrix_to_euler_zyx
  import rmze_pkg::*;
#(
  parameter int CORDIC_STAGES = 18
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ElemW-1:0] m00,
  input  logic signed [ElemW-1:0] m10,
  input  logic signed [ElemW-1:0] m20,
  input  logic signed [ElemW-1:0] m21,
  input  logic signed [ElemW-1:0] m22,
  input  logic signed [ElemW-1:0] m12,
  input  logic signed [ElemW-1:0] m11,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RootW-1:0]        cfg_data,
  output logic                    done,
  output logic signed [AngW-1:0]  yaw,
  output logic signed [AngW-1:0]  pitch,
  output logic signed [AngW-1:0]  roll,
  output logic                    gimbal_lock
);

  logic [RootW-1:0] threshold;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= RootW'(1);
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  elems_t in_elems, sq_elems, sum_elems;
  logic   in_vld, sq_vld, sum_vld;
  logic [SqW-2:0] sq00, sq10;
  logic [SqW-1:0] sum_sq;
  logic signed [2*ElemW-1:0] p00, p10;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_elems.m00 <= clamp_elem(m00);
    in_elems.m10 <= clamp_elem(m10);
    in_elems.m20 <= clamp_elem(m20);
    in_elems.m21 <= clamp_elem(m21);
    in_elems.m22 <= clamp_elem(m22);
    in_elems.m12 <= clamp_elem(m12);
    in_elems.m11 <= clamp_elem(m11);
  end

  assign p00 = in_elems.m00 * in_elems.m00;
  assign p10 = in_elems.m10 * in_elems.m10;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld  <= 1'b0;
      sum_vld <= 1'b0;
    end else begin
      sq_vld  <= in_vld;
      sum_vld <= sq_vld;
    end
    sq00      <= p00[SqW-2:0];
    sq10      <= p10[SqW-2:0];
    sq_elems  <= in_elems;
    sum_sq    <= SqW'(sq00) + SqW'(sq10);
    sum_elems <= sq_elems;
  end

  logic             rt_vld;
  logic [RootW-1:0] sy;
  elems_t           rt_elems;

  rmze_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_vld),
    .in_n      (sum_sq),
    .in_elems  (sum_elems),
    .out_valid (rt_vld),
    .out_root  (sy),
    .out_elems (rt_elems)
  );

  logic lock;
  logic signed [ElemW-1:0] roll_y, roll_x;

  assign lock   = sy < threshold;
  assign roll_y = lock ? -rt_elems.m12 : rt_elems.m21;
  assign roll_x = lock ? rt_elems.m11 : rt_elems.m22;

  logic                   c_vld, c_lock, yaw_lock, roll_lock, yaw_vld, roll_vld;
  logic signed [AngW-1:0] yaw_ang, pitch_ang, roll_ang;

  rmze_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_tag    (lock),
    .in_y      (-rt_elems.m20),
    .in_x      (ElemW'(sy)),
    .out_valid (c_vld),
    .out_tag   (c_lock),
    .out_angle (pitch_ang)
  );

  rmze_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_tag    (lock),
    .in_y      (rt_elems.m10),
    .in_x      (rt_elems.m00),
    .out_valid (yaw_vld),
    .out_tag   (yaw_lock),
    .out_angle (yaw_ang)
  );

  rmze_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_tag    (lock),
    .in_y      (roll_y),
    .in_x      (roll_x),
    .out_valid (roll_vld),
    .out_tag   (roll_lock),
    .out_angle (roll_ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_vld && yaw_vld && roll_vld;
    end
    yaw         <= (c_lock || yaw_lock) ? '0 : yaw_ang;
    pitch       <= pitch_ang;
    roll        <= roll_ang;
    gimbal_lock <= c_lock && roll_lock;
  end

endmodule

// ===== sv/rmze_isqrt.sv =====
module rmze_isqrt
  import rmze_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [SqW-1:0]   in_n,
  input  elems_t           in_elems,
  output logic             out_valid,
  output logic [RootW-1:0] out_root,
  output elems_t           out_elems
);

  logic [SqW-1:0]   rem   [0:RootW];
  logic [RootW-1:0] root  [0:RootW];
  elems_t           elems [0:RootW];
  logic             vld   [0:RootW];

  assign rem[0]   = in_n;
  assign root[0]  = '0;
  assign elems[0] = in_elems;
  assign vld[0]   = in_valid;

  for (genvar k = 0; k < RootW; k++) begin : g_bit
    localparam int B = RootW - 1 - k;
    logic [SqW:0] trial;
    assign trial = ((SqW+1)'(root[k]) << (B + 1)) + ((SqW+1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      elems[k+1] <= elems[k];
      if ({1'b0, rem[k]} >= trial) begin
        rem[k+1]  <= SqW'({1'b0, rem[k]} - trial);
        root[k+1] <= root[k] | (RootW'(1) << B);
      end else begin
        rem[k+1]  <= rem[k];
        root[k+1] <= root[k];
      end
    end
  end

  assign out_valid = vld[RootW];
  assign out_root  = root[RootW];
  assign out_elems = elems[RootW];

endmodule

// ===== sv/rmze_cordic.sv =====
module rmze_cordic
  import rmze_pkg::*;
#(
  parameter int STAGES = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_tag,
  input  logic signed [ElemW-1:0] in_y,
  input  logic signed [ElemW-1:0] in_x,
  output logic                   out_valid,
  output logic                   out_tag,
  output logic signed [AngW-1:0] out_angle
);

  logic signed [XyW-1:0] xs [0:STAGES];
  logic signed [XyW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0]  zs [0:STAGES];
  logic vs [0:STAGES];
  logic ts [0:STAGES];
  logic yz [0:STAGES];
  logic xn [0:STAGES];

  logic signed [XyW-1:0] x_ext, y_ext;
  logic                  x_neg;

  assign x_ext = XyW'(in_x);
  assign y_ext = XyW'(in_y);
  assign x_neg = in_x[ElemW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    ts[0] <= in_tag;
    yz[0] <= (in_y == '0);
    xn[0] <= x_neg;
    if (x_neg) begin
      xs[0] <= (-x_ext) <<< PreShift;
      ys[0] <= (-y_ext) <<< PreShift;
      zs[0] <= in_y[ElemW-1] ? -PiQ30 : PiQ30;
    end else begin
      xs[0] <= x_ext <<< PreShift;
      ys[0] <= y_ext <<< PreShift;
      zs[0] <= '0;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else begin
        vs[g+1] <= vs[g];
      end
      ts[g+1] <= ts[g];
      yz[g+1] <= yz[g];
      xn[g+1] <= xn[g];
      if (ys[g] > 0) begin
        xs[g+1] <= xs[g] + (ys[g] >>> g);
        ys[g+1] <= ys[g] - (xs[g] >>> g);
        zs[g+1] <= zs[g] + stage_angle(g);
      end else begin
        xs[g+1] <= xs[g] - (ys[g] >>> g);
        ys[g+1] <= ys[g] + (xs[g] >>> g);
        zs[g+1] <= zs[g] - stage_angle(g);
      end
    end
  end

  logic signed [ZW:0]    z_rnd;
  logic signed [ZW-14:0] z_q16;
  logic signed [AngW-1:0] angle_next;

  assign z_rnd = (ZW+1)'(zs[STAGES]) + (ZW+1)'(8192);
  assign z_q16 = z_rnd[ZW:14];

  always_comb begin
    if (yz[STAGES]) begin
      angle_next = xn[STAGES] ? PiQ16 : '0;
    end else if (z_q16 > (ZW-13)'(PiQ16)) begin
      angle_next = PiQ16;
    end else if (z_q16 < -((ZW-13)'(PiQ16))) begin
      angle_next = -PiQ16;
    end else begin
      angle_next = z_q16[AngW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vs[STAGES];
    end
    out_tag   <= ts[STAGES];
    out_angle <= angle_next;
  end

endmodule
